>>> src/tlbr_pkg.sv
// Shared types and codes for the set-associative TLB with LRU ranks.
// No dependencies; imported by the way logic and the top level.
`timescale 1ns / 1ps

package tlbr_pkg;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    typedef enum logic [1:0] {
        OUT_HIT       = 2'd0,
        OUT_MISS      = 2'd1,
        OUT_FILL_FREE = 2'd2,
        OUT_FILL_REPL = 2'd3
    } outcome_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [1:0]  way_used;
        logic [31:0] phys_addr;
    } tlbr_result_t;

endpackage

>>> src/tlbr_top.sv
// Top level of the set-associative TLB: request pipeline, set memory and clearing sweep.
// Depends on tlbr_pkg, tlbr_set_mem and tlbr_way_logic.
`timescale 1ns / 1ps

// Usage
//   A request (action, virt_addr, fill_phys_addr) is taken at a rising edge with
//   start high and busy low. action 0 looks up virt_addr; action 1 fills it with
//   the frame of fill_phys_addr. Each request gives one result (outcome,
//   way_used, phys_addr), shown for exactly one cycle with done high.
//   Throughput: one request per cycle while busy is low. The set row is read from
//   a synchronous RAM with registered read data, updated in the next cycle and
//   written back; a request to the set being written in that cycle takes the
//   updated row by forwarding. Reset: after rst_n is released the block clears
//   the valid bits of every set, one set per cycle; busy stays high meanwhile.
//   The receiver cannot stall: done is a strobe and must be taken when shown.
//   SETS must be a power of two; the set index is the low VPN bits, the tag
//   the remaining high bits.
module tlb_4way_lru_rank #(
    parameter int SETS      = 2048,
    parameter int WAYS      = 4,
    parameter int PAGE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] virt_addr,
    input  logic [31:0] fill_phys_addr,
    output logic        done,
    output logic [1:0]  outcome,
    output logic [1:0]  way_used,
    output logic [31:0] phys_addr
);

    import tlbr_pkg::*;

    localparam int SET_BITS = $clog2(SETS);
    localparam int TAG_RAW  = 32 - PAGE_BITS - SET_BITS;
    localparam int TAG_W    = (TAG_RAW < 1) ? 1 : TAG_RAW;
    localparam int FRAME_W  = 32 - PAGE_BITS;
    localparam int WAY_W    = $clog2(WAYS);
    localparam int ROW_W    = WAYS * (1 + TAG_W + FRAME_W + WAY_W);

    logic                  accept;
    logic [SET_BITS-1:0]   idx_in;
    logic [31:0]           tag_shift;

    logic                  sweep_reg;
    logic [SET_BITS-1:0]   sweep_cnt_reg;

    logic                  s1_valid_reg;
    logic                  s1_action_reg;
    logic [SET_BITS-1:0]   s1_idx_reg;
    logic [TAG_W-1:0]      s1_tag_reg;
    logic [FRAME_W-1:0]    s1_frame_reg;
    logic [PAGE_BITS-1:0]  s1_offset_reg;

    logic                  fwd_reg;
    logic [ROW_W-1:0]      fwd_row_reg;

    logic [ROW_W-1:0]      mem_rd_data;
    logic [ROW_W-1:0]      row_cur;
    logic [ROW_W-1:0]      row_new;
    tlbr_result_t          result;

    logic                  wr_en;
    logic [SET_BITS-1:0]   wr_addr;
    logic [ROW_W-1:0]      wr_data;

    logic                  done_reg;
    logic [1:0]            outcome_reg;
    logic [1:0]            way_used_reg;
    logic [31:0]           phys_addr_reg;

    assign busy      = sweep_reg;
    assign accept    = start && !sweep_reg;
    assign idx_in    = virt_addr[PAGE_BITS +: SET_BITS];
    assign tag_shift = virt_addr >> (PAGE_BITS + SET_BITS);

    // Clear every set after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else if (sweep_reg)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + SET_BITS'(1);
            if (sweep_cnt_reg == SET_BITS'(SETS - 1))
            begin
                sweep_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
            // forward the row being written when the next request hits the same set
            fwd_reg      <= accept && s1_valid_reg && idx_in == s1_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_row_reg <= row_new;
        if (accept)
        begin
            s1_action_reg <= action;
            s1_idx_reg    <= idx_in;
            s1_tag_reg    <= tag_shift[TAG_W-1:0];
            s1_frame_reg  <= fill_phys_addr[31:PAGE_BITS];
            s1_offset_reg <= virt_addr[PAGE_BITS-1:0];
        end
        if (s1_valid_reg)
        begin
            outcome_reg   <= result.outcome;
            way_used_reg  <= result.way_used;
            phys_addr_reg <= result.phys_addr;
        end
    end

    assign row_cur = fwd_reg ? fwd_row_reg : mem_rd_data;

    assign wr_en   = sweep_reg || s1_valid_reg;
    assign wr_addr = sweep_reg ? sweep_cnt_reg : s1_idx_reg;
    assign wr_data = sweep_reg ? '0 : row_new;

    tlbr_set_mem #(
        .DEPTH (SETS),
        .WIDTH (ROW_W),
        .AW    (SET_BITS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (idx_in),
        .rd_data (mem_rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    tlbr_way_logic #(
        .WAYS      (WAYS),
        .TAG_W     (TAG_W),
        .PAGE_BITS (PAGE_BITS),
        .ROW_W     (ROW_W)
    ) u_way (
        .action    (s1_action_reg),
        .tag_in    (s1_tag_reg),
        .frame_in  (s1_frame_reg),
        .offset_in (s1_offset_reg),
        .row_in    (row_cur),
        .row_out   (row_new),
        .result    (result)
    );

    assign done      = done_reg;
    assign outcome   = outcome_reg;
    assign way_used  = way_used_reg;
    assign phys_addr = phys_addr_reg;

endmodule

>>> src/tlbr_set_mem.sv
// Single-port-write, single-port-read synchronous RAM holding one TLB set per row.
// Read data is registered; read returns the old row on a collision.
`timescale 1ns / 1ps

module tlbr_set_mem #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8,
    parameter int AW    = 11
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/tlbr_way_logic.sv
// Per-set tag match, fill way choice and LRU rank update on one set row.
// Depends on tlbr_pkg for the outcome codes and the result struct.
`timescale 1ns / 1ps

module tlbr_way_logic #(
    parameter int WAYS      = 4,
    parameter int TAG_W     = 9,
    parameter int PAGE_BITS = 12,
    parameter int ROW_W     = 4
) (
    input  logic                      action,
    input  logic [TAG_W-1:0]          tag_in,
    input  logic [31-PAGE_BITS:0]     frame_in,
    input  logic [PAGE_BITS-1:0]      offset_in,
    input  logic [ROW_W-1:0]          row_in,
    output logic [ROW_W-1:0]          row_out,
    output tlbr_pkg::tlbr_result_t    result
);

    import tlbr_pkg::*;

    localparam int FRAME_W = 32 - PAGE_BITS;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int TAG_B   = WAYS;
    localparam int FRAME_B = TAG_B + WAYS * TAG_W;
    localparam int RANK_B  = FRAME_B + WAYS * FRAME_W;

    logic [WAYS-1:0]    valid;
    logic [TAG_W-1:0]   tags   [WAYS];
    logic [FRAME_W-1:0] frames [WAYS];
    logic [WAY_W-1:0]   ranks  [WAYS];

    logic               hit_found;
    logic [WAY_W-1:0]   hit_way;
    logic               free_found;
    logic [WAY_W-1:0]   free_way;
    logic               top_found;
    logic [WAY_W-1:0]   repl_way;
    logic [WAY_W-1:0]   target;
    logic               promote;
    logic [WAY_W-1:0]   old_rank;
    logic [31:0]        target_ext;

    always_comb
    begin
        valid = row_in[WAYS-1:0];
        for (int w = 0; w < WAYS; w++)
        begin
            tags[w]   = row_in[TAG_B + w * TAG_W +: TAG_W];
            frames[w] = row_in[FRAME_B + w * FRAME_W +: FRAME_W];
            ranks[w]  = row_in[RANK_B + w * WAY_W +: WAY_W];
        end
    end

    // Priority searches: lowest matching way, lowest free way, replacement victim.
    always_comb
    begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        top_found  = 1'b0;
        repl_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && valid[w] && tags[w] == tag_in)
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!free_found && !valid[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
        // fall back to the highest rank, lowest way on a tie
        for (int w = 1; w < WAYS; w++)
        begin
            if (ranks[w] > ranks[repl_way])
            begin
                repl_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (!top_found && ranks[w] == WAY_W'(WAYS - 1))
            begin
                top_found = 1'b1;
                repl_way  = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        if (action == ACT_FILL)
        begin
            target  = free_found ? free_way : repl_way;
            promote = !free_found;
        end
        else
        begin
            target  = hit_found ? hit_way : '0;
            promote = hit_found;
        end
        old_rank   = ranks[target];
        target_ext = 32'(target);
    end

    always_comb
    begin
        row_out = row_in;
        if (action == ACT_FILL)
        begin
            row_out[target] = 1'b1;
            row_out[TAG_B + int'(target) * TAG_W +: TAG_W]       = tag_in;
            row_out[FRAME_B + int'(target) * FRAME_W +: FRAME_W] = frame_in;
            if (free_found)
            begin
                row_out[RANK_B + int'(target) * WAY_W +: WAY_W] = target;
            end
        end
        if (promote)
        begin
            // age every valid way that was more recent than the promoted one
            for (int w = 0; w < WAYS; w++)
            begin
                if (WAY_W'(w) != target && valid[w] && ranks[w] < old_rank)
                begin
                    row_out[RANK_B + w * WAY_W +: WAY_W] = ranks[w] + WAY_W'(1);
                end
            end
            row_out[RANK_B + int'(target) * WAY_W +: WAY_W] = '0;
        end
    end

    always_comb
    begin
        result.way_used  = target_ext[1:0];
        result.phys_addr = '0;
        if (action == ACT_FILL)
        begin
            if (free_found)
            begin
                result.outcome = OUT_FILL_FREE;
            end
            else
            begin
                result.outcome = OUT_FILL_REPL;
            end
        end
        else if (hit_found)
        begin
            result.outcome   = OUT_HIT;
            result.phys_addr = {frames[target], offset_in};
        end
        else
        begin
            result.outcome = OUT_MISS;
        end
    end

endmodule

>>> sim/tlb_4way_lru_rank_tb.sv
// Self-checking testbench for the 4-way set-associative TLB with LRU ranks.
// Depends on tlbr_pkg and tlb_4way_lru_rank; predicts every result in place.
`timescale 1ns / 1ps

module tlb_4way_lru_rank_tb;
    import tlbr_pkg::*;

    localparam int NSETS       = 2048;
    localparam int NWAYS       = 4;
    localparam int RANDOM_REQS = 1630;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic        act;
        logic [31:0] va;
        logic [31:0] pa;
    } tlb_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        action = ACT_LOOKUP;
    logic [31:0] virt_addr = 32'd0;
    logic [31:0] fill_phys_addr = 32'd0;
    logic        busy;
    logic        done;
    logic [1:0]  outcome;
    logic [1:0]  way_used;
    logic [31:0] phys_addr;

    tlb_req_t     pending_reqs[$];
    tlbr_result_t expected_results[$];

    // Shadow copy of the set memory
    bit [3:0]  entry_valid [NSETS];
    bit [8:0]  entry_tag   [NSETS][NWAYS];
    bit [19:0] entry_frame [NSETS][NWAYS];
    bit [1:0]  entry_rank  [NSETS][NWAYS];

    int n_total = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_hit = 0;
    int n_miss = 0;
    int n_free = 0;
    int n_repl = 0;
    int cycles = 0;

    tlb_4way_lru_rank dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .virt_addr      (virt_addr),
        .fill_phys_addr (fill_phys_addr),
        .done           (done),
        .outcome        (outcome),
        .way_used       (way_used),
        .phys_addr      (phys_addr)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] va_of(int tag, int set, int offset);
        return {tag[8:0], set[10:0], offset[11:0]};
    endfunction

    task automatic queue_request(logic act, logic [31:0] va, logic [31:0] pa);
        tlb_req_t r;
        r.act = act;
        r.va  = va;
        r.pa  = pa;
        pending_reqs.push_back(r);
        n_total++;
    endtask

    // Make a way most recently used; ways ranked below its old rank age by one.
    function automatic void make_most_recent(int set, int way);
        bit [1:0] old_rank;
        old_rank = entry_rank[set][way];
        for (int w = 0; w < NWAYS; w++)
        begin
            if (w != way && entry_valid[set][w] && entry_rank[set][w] < old_rank)
                entry_rank[set][w] = entry_rank[set][w] + 2'd1;
        end
        entry_rank[set][way] = 2'd0;
    endfunction

    function automatic tlbr_result_t translate_and_update(logic act, logic [31:0] va,
                                                          logic [31:0] pa);
        tlbr_result_t r;
        int  set;
        int  pick;
        bit  found;
        set = int'(va[22:12]);
        r.outcome   = OUT_MISS;
        r.way_used  = 2'd0;
        r.phys_addr = 32'd0;
        found = 1'b0;
        pick = -1;
        if (act == ACT_LOOKUP)
        begin
            // lowest matching way wins when a page was filled twice
            for (int w = 0; w < NWAYS; w++)
            begin
                if (!found && entry_valid[set][w] && entry_tag[set][w] == va[31:23])
                begin
                    found = 1'b1;
                    r.outcome   = OUT_HIT;
                    r.way_used  = w[1:0];
                    r.phys_addr = {entry_frame[set][w], va[11:0]};
                    make_most_recent(set, w);
                end
            end
        end
        else
        begin
            for (int w = 0; w < NWAYS; w++)
            begin
                if (pick < 0 && !entry_valid[set][w])
                    pick = w;
            end
            if (pick >= 0)
            begin
                r.outcome = OUT_FILL_FREE;
                entry_rank[set][pick] = pick[1:0];
            end
            else
            begin
                // evict the oldest rank; fall back to the highest rank present
                pick = 0;
                for (int w = 1; w < NWAYS; w++)
                begin
                    if (entry_rank[set][w] > entry_rank[set][pick])
                        pick = w;
                end
                for (int w = NWAYS - 1; w >= 0; w--)
                begin
                    if (entry_rank[set][w] == NWAYS - 1)
                        pick = w;
                end
                r.outcome = OUT_FILL_REPL;
            end
            entry_valid[set][pick] = 1'b1;
            entry_tag[set][pick]   = va[31:23];
            entry_frame[set][pick] = pa[31:12];
            if (r.outcome == OUT_FILL_REPL)
                make_most_recent(set, pick);
            r.way_used = pick[1:0];
        end
        return r;
    endfunction

    // Driver: take the next request off the queue unless idling this cycle.
    always @(posedge clk)
    begin
        int popped;
        int idle_pct;
        tlb_req_t r;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(
                    translate_and_update(action, virt_addr, fill_phys_addr));
                n_accepted++;
            end
            popped = n_total - pending_reqs.size();
            if (popped < n_total / 3)
                idle_pct = 31;
            else if (popped < (2 * n_total) / 3)
                idle_pct = 86;
            else
                idle_pct = 0;
            // hold the request while busy
            if (!(start && busy))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    r = pending_reqs.pop_front();
                    start          <= 1'b1;
                    action         <= r.act;
                    virt_addr      <= r.va;
                    fill_phys_addr <= r.pa;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest prediction.
    always @(posedge clk)
    begin
        tlbr_result_t exp_r;
        if (rst_n && done)
        begin
            case (outcome)
                OUT_HIT:       n_hit++;
                OUT_MISS:      n_miss++;
                OUT_FILL_FREE: n_free++;
                default:       n_repl++;
            endcase
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no request pending: outcome %0d way %0d phys %h",
                         $time, outcome, way_used, phys_addr);
                n_errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (outcome !== exp_r.outcome)
                begin
                    $display("%0t: outcome expected %0d actual %0d",
                             $time, exp_r.outcome, outcome);
                    n_errors++;
                end
                if (way_used !== exp_r.way_used)
                begin
                    $display("%0t: way_used expected %0d actual %0d",
                             $time, exp_r.way_used, way_used);
                    n_errors++;
                end
                if (phys_addr !== exp_r.phys_addr)
                begin
                    $display("%0t: phys_addr expected %h actual %h",
                             $time, exp_r.phys_addr, phys_addr);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("tlb_4way_lru_rank_tb failed");
            $finish;
        end
    end

    initial
    begin
        int hot_set[8];
        int hot_tag[6];
        int set_i;
        set_i = 0;

        // Directed: address extremes, free fills, replacement, duplicate page
        queue_request(ACT_LOOKUP, 32'h0000_0000, 32'h0);
        queue_request(ACT_LOOKUP, 32'hffff_ffff, 32'h0);
        queue_request(ACT_FILL,   32'h0000_0000, 32'hffff_ffff);
        queue_request(ACT_LOOKUP, 32'h0000_0fff, 32'h0);
        queue_request(ACT_FILL,   va_of(1, 0, 0), 32'h0000_0000);
        queue_request(ACT_FILL,   va_of(2, 0, 0), 32'h5555_5555);
        queue_request(ACT_FILL,   va_of(3, 0, 0), 32'haaaa_aaaa);
        queue_request(ACT_FILL,   va_of(4, 0, 0), 32'h0123_4567);
        queue_request(ACT_FILL,   va_of(1, 0, 0), 32'h89ab_cdef);
        queue_request(ACT_LOOKUP, va_of(1, 0, 12'habc), 32'h0);
        queue_request(ACT_LOOKUP, va_of(4, 0, 12'h001), 32'h0);
        queue_request(ACT_LOOKUP, va_of(2, 0, 12'h800), 32'h0);
        queue_request(ACT_LOOKUP, va_of(0, 0, 12'hfff), 32'h0);
        queue_request(ACT_FILL,   va_of(6, 0, 0), 32'hffff_f000);
        queue_request(ACT_FILL,   32'hffff_ffff, 32'h0000_0000);
        queue_request(ACT_LOOKUP, 32'hffff_ffff, 32'h0);
        queue_request(ACT_LOOKUP, 32'hffff_f000, 32'h0);
        queue_request(ACT_FILL,   va_of(5, 2047, 0), 32'h0000_0fff);
        queue_request(ACT_LOOKUP, va_of(5, 2047, 12'h123), 32'h0);
        queue_request(ACT_FILL,   va_of(511, 2047, 0), 32'hdead_b000);
        queue_request(ACT_LOOKUP, va_of(511, 2047, 12'h7ff), 32'h0);

        // Random: a few hot sets and tags so hits, evictions and forwarding recur
        hot_set[0] = 0;
        hot_set[1] = NSETS - 1;
        for (int i = 2; i < 8; i++)
            hot_set[i] = $urandom_range(0, NSETS - 1);
        hot_tag[0] = 0;
        hot_tag[1] = 511;
        for (int i = 2; i < 6; i++)
            hot_tag[i] = $urandom_range(0, 511);
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                queue_request(1'($urandom_range(0, 1)), $urandom, $urandom);
            end
            else
            begin
                // stay on the same set now and then to hit back-to-back updates
                if ($urandom_range(0, 99) >= 30)
                    set_i = $urandom_range(0, 7);
                queue_request(($urandom_range(0, 99) < 35) ? ACT_FILL : ACT_LOOKUP,
                              va_of(hot_tag[$urandom_range(0, 5)], hot_set[set_i],
                                    $urandom_range(0, 4095)),
                              $urandom);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_accepted == n_total && expected_results.size() == 0);
        repeat (10) @(posedge clk);

        $display("Checked %0d requests: %0d hits, %0d misses, %0d free fills, %0d evictions.",
                 n_checked, n_hit, n_miss, n_free, n_repl);
        $display("Sender ran at 31%% idle, then 86%% idle, then back-to-back.");
        if (n_errors == 0)
            $display("tlb_4way_lru_rank_tb passed");
        else
            $display("tlb_4way_lru_rank_tb failed");
        $finish;
    end

endmodule
